/* rtl/core/pfd_pkg.sv */
package pfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int CRC_W       = 16;
    localparam int NUM_WORDS   = 6;
    localparam int CNT_W       = 5;
    localparam int WIDX_W      = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] FRAME_ID_BYTE  = 8'h01;
    localparam logic [BYTE_W-1:0] FRAME_LEN_BYTE = 8'h18;
    localparam logic [CNT_W-1:0]  PAYLOAD_BYTES  = 5'd24;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_TAIL_FIRST    = 2'd2,
        CFG_TAIL_SECOND   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HEAD0   = 3'd0,
        PH_HEAD1   = 3'd1,
        PH_ID      = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5,
        PH_TAIL0   = 3'd6,
        PH_TAIL1   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic [CRC_W-1:0]                 crc;
    } frame_t;

endpackage

/* rtl/core/position_frame_deframer.sv */
// Position frame deframer.
// Input channel (in_valid/in_stall): one received byte per item, with
// buffer_start marking the first byte of a receive buffer; that byte
// restarts the parser and is then parsed as the first hunted byte.
// Frame: header_first, header_second, 0x01, 0x18, 24 payload bytes,
// 2 crc bytes (not checked), tail_first, tail_second.
// Output channel (out_valid/out_stall): one item per frame whose second
// tail byte matches: six little-endian payload words and the crc.
// After the second tail byte (match or not) bytes are dropped until the
// next buffer start.
// Throughput: one byte per cycle while in_stall is low; the phase/counter
// update is a single register stage. A matching last tail byte registers
// its result into the output register, or into the skid entry if stalled.
// A result register plus one skid entry sit on the output; in_stall rises
// only when both are full, i.e. the receiver stalled with a result pending
// and another one completed meanwhile.
// Configuration writes (cfg_wr_en/cfg_index/cfg_data) are registered.
// Reset: config registers to zero, parser hunting the first header byte,
// output empty.
module position_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfd_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfd_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          buffer_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pfd_pkg::WORD_W-1:0]    word_zero,
    output logic [pfd_pkg::WORD_W-1:0]    word_one,
    output logic [pfd_pkg::WORD_W-1:0]    word_two,
    output logic [pfd_pkg::WORD_W-1:0]    word_three,
    output logic [pfd_pkg::WORD_W-1:0]    word_four,
    output logic [pfd_pkg::WORD_W-1:0]    word_five,
    output logic [pfd_pkg::CRC_W-1:0]     crc_field
);

    import pfd_pkg::*;

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] tail_first_reg;
    logic [BYTE_W-1:0] tail_second_reg;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              halted_reg, halted_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [NUM_WORDS-1:0][WORD_W-1:0] payload_reg;

    logic              pay_wr;
    logic [WIDX_W-1:0] pay_widx;
    logic [1:0]        pay_bsel;

    logic              in_fire;
    logic              emit;
    logic              res_fire;
    frame_t            res_frame;

    frame_t            out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    frame_t            skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= '0;
            header_second_reg <= '0;
            tail_first_reg    <= '0;
            tail_second_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                CFG_TAIL_FIRST:    tail_first_reg    <= cfg_data;
                CFG_TAIL_SECOND:   tail_second_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // parser next state
    always_comb
    begin
        phase_t           ph;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] cnt_inc;

        ph          = phase_reg;
        cnt         = count_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        crc_next    = crc_reg;
        pay_wr      = 1'b0;
        pay_widx    = count_reg[CNT_W-1:2];
        pay_bsel    = count_reg[1:0];
        emit        = 1'b0;
        cnt_inc     = count_reg + CNT_W'(1);

        if (in_fire)
        begin
            if (buffer_start)
            begin
                ph          = PH_HEAD0;
                cnt         = '0;
                halted_next = 1'b0;
                phase_next  = PH_HEAD0;
                count_next  = '0;
            end
            pay_widx = cnt[CNT_W-1:2];
            pay_bsel = cnt[1:0];
            cnt_inc  = cnt + CNT_W'(1);

            if (!halted_next)
            begin
                case (ph)
                    PH_HEAD0:
                        phase_next = (rx_byte == header_first_reg) ? PH_HEAD1 : PH_HEAD0;
                    PH_HEAD1:
                        phase_next = (rx_byte == header_second_reg) ? PH_ID : PH_HEAD0;
                    PH_ID:
                        phase_next = (rx_byte == FRAME_ID_BYTE) ? PH_LEN : PH_HEAD0;
                    PH_LEN:
                    begin
                        phase_next = (rx_byte == FRAME_LEN_BYTE) ? PH_PAYLOAD : PH_HEAD0;
                        count_next = '0;
                    end
                    PH_PAYLOAD:
                    begin
                        pay_wr = 1'b1;
                        if (cnt_inc >= PAYLOAD_BYTES)
                        begin
                            count_next = '0;
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            count_next = cnt_inc;
                        end
                    end
                    PH_CRC:
                    begin
                        if (cnt == '0)
                        begin
                            crc_next   = {crc_reg[CRC_W-1:BYTE_W], rx_byte};
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            crc_next   = {rx_byte, crc_reg[BYTE_W-1:0]};
                            count_next = '0;
                            phase_next = PH_TAIL0;
                        end
                    end
                    PH_TAIL0:
                        phase_next = (rx_byte == tail_first_reg) ? PH_TAIL1 : PH_HEAD0;
                    PH_TAIL1:
                    begin
                        phase_next  = PH_HEAD0;
                        count_next  = '0;
                        halted_next = 1'b1;
                        emit        = (rx_byte == tail_second_reg);
                    end
                    default:
                    begin
                        phase_next = PH_HEAD0;
                        count_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            crc_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            crc_reg    <= crc_next;
        end
    end

    // payload store, one byte lane written per item
    always_ff @(posedge clk)
    begin
        if (pay_wr && (pay_widx < WIDX_W'(NUM_WORDS)))
        begin
            case (pay_bsel)
                2'd0:    payload_reg[pay_widx][7:0]   <= rx_byte;
                2'd1:    payload_reg[pay_widx][15:8]  <= rx_byte;
                2'd2:    payload_reg[pay_widx][23:16] <= rx_byte;
                default: payload_reg[pay_widx][31:24] <= rx_byte;
            endcase
        end
    end

    // result: the crc is complete by the last tail byte, payload too
    assign res_fire        = emit;
    assign res_frame.words = payload_reg;
    assign res_frame.crc   = crc_reg;

    // output register plus skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res_frame;
                out_valid_next = res_fire;
            end
        end
        else if (res_fire)
        begin
            skid_next       = res_frame;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign word_zero  = out_reg.words[0];
    assign word_one   = out_reg.words[1];
    assign word_two   = out_reg.words[2];
    assign word_three = out_reg.words[3];
    assign word_four  = out_reg.words[4];
    assign word_five  = out_reg.words[5];
    assign crc_field  = out_reg.crc;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled result");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < PAYLOAD_BYTES))
        else $error("payload byte count out of range");

    a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (phase_reg == PH_HEAD0 && count_reg == '0))
        else $error("halted parser not parked in hunt");

    a_emit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> halted_reg)
        else $error("parser not halted after a frame");

endmodule
